// ----- hdl/spoc_pkg.sv -----
// Package for the stable pair order counter.
// Holds the item structs, the configuration register indexes and the internal stage types.
// No dependencies.
package spoc_pkg;

	localparam int CountWidth = 16;
	localparam int CfgIndexWidth = 3;
	localparam int CfgDataWidth = 16;

	localparam logic [CfgIndexWidth-1:0] REG_SOURCE_ROWS = 3'd0;
	localparam logic [CfgIndexWidth-1:0] REG_TARGET_ROWS = 3'd1;
	localparam logic [CfgIndexWidth-1:0] REG_STABLE_BOUND = 3'd2;
	localparam logic [CfgIndexWidth-1:0] REG_REVERSAL_BOUND = 3'd3;
	localparam logic [CfgIndexWidth-1:0] REG_REVERSE_MODE = 3'd4;

	typedef struct packed {
		logic               op;
		logic signed [31:0] first_value;
		logic signed [31:0] second_value;
		logic [15:0]        first_gene;
		logic [15:0]        second_gene;
		logic               last;
	} spoc_in_t;

	typedef struct packed {
		logic [15:0] higher_gene;
		logic [15:0] lower_gene;
		logic [15:0] source_count;
		logic [15:0] target_count;
	} spoc_out_t;

	typedef struct packed {
		logic [15:0] source_rows;
		logic [15:0] target_rows;
		logic [15:0] stable_bound;
		logic [15:0] reversal_bound;
		logic        reverse_mode;
	} spoc_cfg_t;

	// A sample after classification: which counter it raises, plus the pair and last flag.
	typedef struct packed {
		logic        inc_greater;
		logic        inc_less;
		logic [15:0] first_gene;
		logic [15:0] second_gene;
		logic        last;
	} spoc_smp_t;

	typedef struct packed {
		logic [CountWidth-1:0] greater;
		logic [CountWidth-1:0] less;
	} spoc_cnt_t;

endpackage

// ----- hdl/spoc_in_stage.sv -----
// Input register stage of the stable pair order counter.
// Compares the two values of a sample and registers the classified item.
// Depends on spoc_pkg.
module spoc_in_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  spoc_pkg::spoc_in_t  in_item,
	input  logic                reverse_mode,
	input  logic                adv,
	output logic                valid_s1,
	output spoc_pkg::spoc_smp_t smp_s1
);
	import spoc_pkg::*;

	logic      is_target;
	spoc_smp_t smp_d;

	assign in_ready = !valid_s1 || adv;
	assign is_target = reverse_mode && in_item.op;

	always_comb begin
		smp_d.inc_greater = !is_target && (in_item.first_value > in_item.second_value);
		smp_d.inc_less = is_target && (in_item.first_value < in_item.second_value);
		smp_d.first_gene = in_item.first_gene;
		smp_d.second_gene = in_item.second_gene;
		smp_d.last = in_item.last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			smp_s1 <= smp_d;
		end
	end

endmodule

// ----- hdl/spoc_counter.sv -----
// Saturating sample counters of the stable pair order counter.
// Gives the counts including the current item and clears them after the last item.
// Depends on spoc_pkg.
module spoc_counter #(
	parameter logic [15:0] CountCap = 16'd65535
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  spoc_pkg::spoc_smp_t smp_s1,
	output spoc_pkg::spoc_cnt_t cnt
);
	import spoc_pkg::*;

	logic [CountWidth-1:0] greater_q;
	logic [CountWidth-1:0] less_q;

	always_comb begin
		cnt.greater = greater_q;
		cnt.less = less_q;
		if (smp_s1.inc_greater && greater_q < CountCap) begin
			cnt.greater = greater_q + 1'b1;
		end
		if (smp_s1.inc_less && less_q < CountCap) begin
			cnt.less = less_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			greater_q <= '0;
			less_q <= '0;
		end else if (step) begin
			if (smp_s1.last) begin
				greater_q <= '0;
				less_q <= '0;
			end else begin
				greater_q <= cnt.greater;
				less_q <= cnt.less;
			end
		end
	end

	// Counters are empty after each pair has been decided.
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(step && smp_s1.last) |=> (greater_q == '0 && less_q == '0))
		else $error("counters not cleared after last item");

	a_greater_cap: assert property (@(posedge clk) disable iff (!arst_n)
		greater_q <= CountCap)
		else $error("greater count above cap");

	a_less_cap: assert property (@(posedge clk) disable iff (!arst_n)
		less_q <= CountCap)
		else $error("less count above cap");

endmodule

// ----- hdl/spoc_decide.sv -----
// Decision logic and result register of the stable pair order counter.
// Orients a passing pair on its last item; holds it until it is taken.
// Depends on spoc_pkg.
module spoc_decide (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  spoc_pkg::spoc_smp_t smp_s1,
	input  spoc_pkg::spoc_cnt_t cnt,
	input  spoc_pkg::spoc_cfg_t cfg,
	output logic                adv,
	output logic                out_valid,
	input  logic                out_ready,
	output spoc_pkg::spoc_out_t out_item
);
	import spoc_pkg::*;

	logic [15:0] g_comp;
	logic [15:0] l_comp;
	logic        fwd_ok;
	logic        rev_ok;
	logic        rows_ok;
	logic        emit;
	spoc_out_t   res;
	logic        out_valid_q;
	spoc_out_t   out_q;

	assign adv = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_item = out_q;

	always_comb begin
		g_comp = (cfg.source_rows > cnt.greater) ? cfg.source_rows - cnt.greater : '0;
		l_comp = (cfg.target_rows > cnt.less) ? cfg.target_rows - cnt.less : '0;
		if (cfg.reverse_mode) begin
			rows_ok = (cfg.source_rows != '0) && (cfg.target_rows != '0);
			fwd_ok = (cnt.greater > cfg.stable_bound) && (cnt.less > cfg.reversal_bound);
			rev_ok = (g_comp > cfg.stable_bound) && (l_comp > cfg.reversal_bound);
		end else begin
			rows_ok = cfg.source_rows != '0;
			fwd_ok = cnt.greater > cfg.stable_bound;
			rev_ok = g_comp > cfg.stable_bound;
		end
		emit = smp_s1.last && rows_ok && (fwd_ok || rev_ok);
		if (fwd_ok) begin
			res.higher_gene = smp_s1.first_gene;
			res.lower_gene = smp_s1.second_gene;
			res.source_count = cnt.greater;
			res.target_count = cfg.reverse_mode ? cnt.less : '0;
		end else begin
			res.higher_gene = smp_s1.second_gene;
			res.lower_gene = smp_s1.first_gene;
			res.source_count = g_comp;
			res.target_count = cfg.reverse_mode ? l_comp : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && emit) begin
			out_q <= res;
		end
	end

	// A fresh result always beats the stable bound that decided it.
	a_result_above_bound: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> (out_q.source_count > $past(cfg.stable_bound)))
		else $error("result source count not above stable bound");

endmodule

// ----- hdl/stable_pair_order_counter.sv -----
// Stable pair order counter: counts ordered samples per gene pair and emits the oriented pair.
// Path: a last item passes the input register and then the result register before its result is offered.
// Throughput: one item per cycle while results are taken; a waiting result holds the input
// register, so the input stalls once that register is full.
// Reset: clears the configuration registers, both counters and all valid flags.
// Depends on spoc_pkg, spoc_in_stage, spoc_counter and spoc_decide.
module stable_pair_order_counter #(
	parameter int MAX_SAMPLES = 65535
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  spoc_pkg::spoc_in_t                   in_item,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output spoc_pkg::spoc_out_t                  out_item,
	input  logic                                 cfg_we,
	input  logic [spoc_pkg::CfgIndexWidth-1:0]   cfg_index,
	input  logic [spoc_pkg::CfgDataWidth-1:0]    cfg_data
);
	import spoc_pkg::*;

	localparam logic [15:0] CountCap = (MAX_SAMPLES < 65535) ? 16'(MAX_SAMPLES) : 16'd65535;

	spoc_cfg_t cfg_q;
	logic      adv;
	logic      valid_s1;
	spoc_smp_t smp_s1;
	spoc_cnt_t cnt;
	logic      step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SOURCE_ROWS:    cfg_q.source_rows <= cfg_data;
				REG_TARGET_ROWS:    cfg_q.target_rows <= cfg_data;
				REG_STABLE_BOUND:   cfg_q.stable_bound <= cfg_data;
				REG_REVERSAL_BOUND: cfg_q.reversal_bound <= cfg_data;
				REG_REVERSE_MODE:   cfg_q.reverse_mode <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	assign step = valid_s1 && adv;

	spoc_in_stage u_in_stage (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.in_item      (in_item),
		.reverse_mode (cfg_q.reverse_mode),
		.adv          (adv),
		.valid_s1     (valid_s1),
		.smp_s1       (smp_s1)
	);

	spoc_counter #(
		.CountCap (CountCap)
	) u_counter (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.smp_s1 (smp_s1),
		.cnt    (cnt)
	);

	spoc_decide u_decide (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.smp_s1    (smp_s1),
		.cnt       (cnt),
		.cfg       (cfg_q),
		.adv       (adv),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	// With the result register empty the input side never stalls.
	a_ready_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty result register");

endmodule
